// ----- hdl/h2r_pkg.sv -----
// ---------------------------------------------------------------------------
// HSL to RGB converter package
// Shared constants for the converter and its port checker.
// ---------------------------------------------------------------------------
package h2r_pkg;

    // Default number of fraction bits for saturation and lightness.
    localparam int FRAC_BITS_DEF = 12;

    // Hue is an angle in 1536ths of a turn.
    localparam int HUE_W = 11;

    // Width of one output color channel.
    localparam int CHAN_W = 8;

    // Number of register stages from the input beat to the output beat.
    localparam int PIPE_DEPTH = 6;

    // Hue landmarks, held one bit wider than the hue so sums fit.
    localparam logic [HUE_W:0] HUE_TURN       = 12'd1536;
    localparam logic [HUE_W:0] HUE_SIXTH      = 12'd256;
    localparam logic [HUE_W:0] HUE_THIRD      = 12'd512;
    localparam logic [HUE_W:0] HUE_HALF_TURN  = 12'd768;
    localparam logic [HUE_W:0] HUE_TWO_THIRDS = 12'd1024;

endpackage

// ----- hdl/hsl_to_rgb_converter.sv -----
// Throughput: one pixel per cycle while the output is not stalled; each of
// the six stages holds one pixel and a stage advances whenever the stage
// after it is empty or advancing.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only; the
// data path registers are not reset.
// ---------------------------------------------------------------------------
// HSL to RGB converter
// Converts one HSL pixel per beat into 8-bit RGB through a six-stage pipeline:
// clamp, multiply, q, p and slope, ramp, then scale by 255 with rounding.
// ---------------------------------------------------------------------------
module hsl_to_rgb_converter
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SW       = FRAC_BITS + 1,
    localparam int IN_BITS  = HUE_W + 2 * SW,
    localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_TW   = 3 * CHAN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0 up: hue, saturation, lightness, zero fill.
    input  logic [IN_TW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Fields from bit 0 up: red, green, blue.
    output logic [OUT_TW-1:0] m_axis_tdata
);

    localparam int LSW   = 2 * SW;
    localparam int Q2W   = 2 * FRAC_BITS + 1;
    localparam int NUMW  = 2 * FRAC_BITS + 9;
    localparam int PRODW = NUMW + 8;
    localparam int RSH   = 2 * FRAC_BITS + 8;
    localparam int DW    = 9;

    localparam logic [SW-1:0]    ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SW-1:0]    HALF     = {2'b01, {(FRAC_BITS - 1){1'b0}}};
    localparam logic [PRODW-1:0] ROUND_UP = {{(PRODW - RSH){1'b0}}, 1'b1, {(RSH - 1){1'b0}}};

    // Ramp weight for one channel angle: rising, flat, falling, or zero.
    function automatic logic [DW-1:0] ramp_weight(input logic [HUE_W:0] t);
        logic [DW-1:0] w;
        if (t < HUE_SIXTH) begin
            w = t[DW-1:0];
        end else if (t < HUE_HALF_TURN) begin
            w = HUE_SIXTH[DW-1:0];
        end else if (t < HUE_TWO_THIRDS) begin
            w = DW'(HUE_TWO_THIRDS - t);
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // Wraps a hue plus an offset back into one turn.
    function automatic logic [HUE_W:0] hue_offset(input logic [HUE_W-1:0] h,
                                                  input logic [HUE_W:0]   ofs);
        logic [HUE_W:0] t;
        t = {1'b0, h} + ofs;
        if (t >= HUE_TURN) begin
            t = t - HUE_TURN;
        end
        return t;
    endfunction

    // -----------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads.
    // -----------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH:0]   w_rdy;
    logic [PIPE_DEPTH-1:0] n_vld;

    always_comb begin
        w_rdy[PIPE_DEPTH] = m_axis_tready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_vld[0] = s_axis_tvalid;
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    // -----------------------------------------------------------------------
    // Stage 1: unpack, wrap the hue into one turn, clamp S and L to 1.0.
    // -----------------------------------------------------------------------
    logic [HUE_W-1:0] w_hue_in;
    logic [SW-1:0]    w_s_in;
    logic [SW-1:0]    w_l_in;
    logic [HUE_W-1:0] n_s1_hue;
    logic [SW-1:0]    n_s1_s;
    logic [SW-1:0]    n_s1_l;
    logic [HUE_W-1:0] r_s1_hue;
    logic [SW-1:0]    r_s1_s;
    logic [SW-1:0]    r_s1_l;

    assign w_hue_in = s_axis_tdata[HUE_W-1:0];
    assign w_s_in   = s_axis_tdata[HUE_W+SW-1:HUE_W];
    assign w_l_in   = s_axis_tdata[HUE_W+2*SW-1:HUE_W+SW];

    always_comb begin
        n_s1_hue = ({1'b0, w_hue_in} >= HUE_TURN) ? HUE_W'({1'b0, w_hue_in} - HUE_TURN)
                                                  : w_hue_in;
        n_s1_s   = (w_s_in > ONE) ? ONE : w_s_in;
        n_s1_l   = (w_l_in > ONE) ? ONE : w_l_in;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_hue <= n_s1_hue;
            r_s1_s   <= n_s1_s;
            r_s1_l   <= n_s1_l;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: L*S product, gray level, zero-saturation flag, ramp weights.
    // -----------------------------------------------------------------------
    logic [SW+7:0]   w_l255;
    logic [LSW-1:0]  n_s2_ls;
    logic [CHAN_W-1:0] n_s2_gray;
    logic [DW-1:0]   n_s2_d [3];
    logic [LSW-1:0]  r_s2_ls;
    logic [SW-1:0]   r_s2_s;
    logic [SW-1:0]   r_s2_l;
    logic            r_s2_zero;
    logic [CHAN_W-1:0] r_s2_gray;
    logic [DW-1:0]   r_s2_d [3];

    always_comb begin
        n_s2_ls   = LSW'(r_s1_l) * LSW'(r_s1_s);
        w_l255    = {r_s1_l, 8'd0} - {8'd0, r_s1_l};
        n_s2_gray = w_l255[FRAC_BITS+7:FRAC_BITS];
        // Red leads by a third of a turn, blue trails by a third.
        n_s2_d[0] = ramp_weight(hue_offset(r_s1_hue, HUE_THIRD));
        n_s2_d[1] = ramp_weight({1'b0, r_s1_hue});
        n_s2_d[2] = ramp_weight(hue_offset(r_s1_hue, HUE_TWO_THIRDS));
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_ls   <= n_s2_ls;
            r_s2_s    <= r_s1_s;
            r_s2_l    <= r_s1_l;
            r_s2_zero <= (r_s1_s == '0);
            r_s2_gray <= n_s2_gray;
            r_s2_d    <= n_s2_d;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3: q at twice the fraction width.
    // -----------------------------------------------------------------------
    logic [LSW:0]    w_q_lo;
    logic [LSW:0]    w_q_hi;
    logic [Q2W-1:0]  n_s3_q2;
    logic [Q2W-1:0]  r_s3_q2;
    logic [SW-1:0]   r_s3_l;
    logic            r_s3_zero;
    logic [CHAN_W-1:0] r_s3_gray;
    logic [DW-1:0]   r_s3_d [3];

    always_comb begin
        w_q_lo  = {2'b00, r_s2_l, {FRAC_BITS{1'b0}}} + {1'b0, r_s2_ls};
        w_q_hi  = {2'b00, r_s2_l, {FRAC_BITS{1'b0}}} + {2'b00, r_s2_s, {FRAC_BITS{1'b0}}}
                  - {1'b0, r_s2_ls};
        n_s3_q2 = (r_s2_l < HALF) ? w_q_lo[Q2W-1:0] : w_q_hi[Q2W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_q2   <= n_s3_q2;
            r_s3_l    <= r_s2_l;
            r_s3_zero <= r_s2_zero;
            r_s3_gray <= r_s2_gray;
            r_s3_d    <= r_s2_d;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 4: p = 2L - q and the ramp slope q - p.
    // -----------------------------------------------------------------------
    logic [Q2W:0]    w_p2;
    logic [Q2W-1:0]  n_s4_p2;
    logic [Q2W-1:0]  n_s4_diff;
    logic [Q2W-1:0]  r_s4_p2;
    logic [Q2W-1:0]  r_s4_diff;
    logic            r_s4_zero;
    logic [CHAN_W-1:0] r_s4_gray;
    logic [DW-1:0]   r_s4_d [3];

    always_comb begin
        w_p2      = {r_s3_l, {(FRAC_BITS + 1){1'b0}}} - {1'b0, r_s3_q2};
        n_s4_p2   = w_p2[Q2W-1:0];
        n_s4_diff = r_s3_q2 - n_s4_p2;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s4_p2   <= n_s4_p2;
            r_s4_diff <= n_s4_diff;
            r_s4_zero <= r_s3_zero;
            r_s4_gray <= r_s3_gray;
            r_s4_d    <= r_s3_d;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 5: ramp numerator p*256 + (q-p)*weight for each channel.
    // -----------------------------------------------------------------------
    logic [NUMW-1:0] n_s5_num [3];
    logic [NUMW-1:0] r_s5_num [3];
    logic            r_s5_zero;
    logic [CHAN_W-1:0] r_s5_gray;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s5_num[c] = {r_s4_p2, 8'd0} + NUMW'(r_s4_diff) * NUMW'(r_s4_d[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s5_num  <= n_s5_num;
            r_s5_zero <= r_s4_zero;
            r_s5_gray <= r_s4_gray;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 6: scale by 255 with half-up rounding, or pass the gray level.
    // -----------------------------------------------------------------------
    logic [PRODW-1:0]  w_prod [3];
    logic [CHAN_W-1:0] n_s6_chan [3];
    logic [CHAN_W-1:0] r_s6_chan [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_prod[c] = {r_s5_num[c], 8'd0} - PRODW'(r_s5_num[c]) + ROUND_UP;
            n_s6_chan[c] = r_s5_zero ? r_s5_gray : w_prod[c][RSH+CHAN_W-1:RSH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_s6_chan <= n_s6_chan;
        end
    end

    assign m_axis_tdata = {r_s6_chan[2], r_s6_chan[1], r_s6_chan[0]};

endmodule

// ----- hdl/h2r_checker.sv -----
// ---------------------------------------------------------------------------
// HSL to RGB converter port checker
// Watches the converter's stream ports for handshake, latency and black
// pixel behavior.
// ---------------------------------------------------------------------------
module h2r_port_assert
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SW       = FRAC_BITS + 1,
    localparam int IN_BITS  = HUE_W + 2 * SW,
    localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_TW   = 3 * CHAN_W
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              i_s_tready,
    input logic [IN_TW-1:0]  i_s_tdata,
    input logic              i_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_TW-1:0] i_m_tdata
);

    logic w_s_beat;
    logic w_black_in;

    assign w_s_beat   = i_s_tvalid && i_s_tready;
    assign w_black_in = (i_s_tdata[HUE_W+SW-1:HUE_W] == '0) &&
                        (i_s_tdata[HUE_W+2*SW-1:HUE_W+SW] == '0);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

    // The input only stalls while a result waits at a stalled output.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_m_tvalid || i_m_tready) |-> i_s_tready)
        else $error("input stalled while output side could move");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled output beat changed");

    // With the output open, a pixel of zero saturation and lightness comes
    // out black once it has passed through the pipeline.
    a_black_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_beat && w_black_in) ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready
        ##1 i_m_tready ##1 i_m_tready |=> (i_m_tvalid && i_m_tdata == '0))
        else $error("black pixel not delivered on time");

endmodule

bind hsl_to_rgb_converter h2r_port_assert #(
    .FRAC_BITS (FRAC_BITS)
) u_h2r_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tdata  (s_axis_tdata),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
